FILE: design/qphs_pkg.sv
`timescale 1ns / 1ps

package qphs_pkg;

    localparam int DEPTH       = 1024;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int PROBE_LIMIT = 21;
    localparam int PROBE_W     = $clog2(PROBE_LIMIT);
    localparam int KEY_W       = 31;
    localparam int SIZE_W      = 11;
    localparam int BIT_W       = $clog2(KEY_W);
    localparam int ENTRY_W     = KEY_W + 1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1021);
    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(DEPTH);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_SPARE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_UPDATE,
        S_OUT
    } state_t;

    localparam logic [1:0] REG_TABLE_SIZE = 2'd0;

endpackage

FILE: design/quadratic_probe_hash_set.sv
`timescale 1ns / 1ps

// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// in       | in_valid, in_ready, mode, key             | in
// out      | out_valid, out_ready, status, found, slot,| out
//          | count                                     |
// config   | psel, penable, pwrite, paddr, pwdata,     | in/out
//          | prdata, pready                            |
// A transaction is accepted in the idle state, reduces its key modulo the table
// size bit-serially over its 31 bits, runs 21 probes, each a read of the
// single-port slot memory and then a compare, and ends with an update and an
// output step; no new input is taken until the block is idle again. After reset
// a clearing pass writes all 1024 slots, one per cycle, before the first input
// transaction is taken. A stalled result holds the next transaction in its
// output state until the output register frees.

module quadratic_probe_hash_set
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        mode,
    input  logic [qphs_pkg::KEY_W-1:0]        key,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic                              found,
    output logic [qphs_pkg::ADDR_W-1:0]       slot,
    output logic [qphs_pkg::SIZE_W-1:0]       count,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [1:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    qphs_pkg::state_t                  state_reg, state_next;
    logic [qphs_pkg::SIZE_W-1:0]       size_cfg_reg;
    logic [qphs_pkg::SIZE_W-1:0]       size_reg;
    qphs_pkg::mode_t                   mode_reg;
    logic [qphs_pkg::KEY_W-1:0]        key_reg;
    logic [qphs_pkg::BIT_W-1:0]        bit_reg;
    logic [qphs_pkg::SIZE_W-1:0]       rem_reg;
    logic [qphs_pkg::SIZE_W-1:0]       pos_reg;
    logic [qphs_pkg::SIZE_W-1:0]       off_reg;
    logic [qphs_pkg::PROBE_W-1:0]      probe_reg;
    logic                              hit_reg;
    logic [qphs_pkg::ADDR_W-1:0]       hit_slot_reg;
    logic                              empty_reg;
    logic [qphs_pkg::ADDR_W-1:0]       empty_slot_reg;
    logic [qphs_pkg::SIZE_W-1:0]       count_reg;
    logic [qphs_pkg::ADDR_W:0]         clr_reg;
    logic [1:0]                        res_status_reg;
    logic                              res_found_reg;
    logic [qphs_pkg::ADDR_W-1:0]       res_slot_reg;
    logic                              out_valid_reg;
    logic [1:0]                        out_status_reg;
    logic                              out_found_reg;
    logic [qphs_pkg::ADDR_W-1:0]       out_slot_reg;
    logic [qphs_pkg::SIZE_W-1:0]       out_count_reg;

    logic [qphs_pkg::ENTRY_W-1:0]      mem [qphs_pkg::DEPTH];
    logic [qphs_pkg::ENTRY_W-1:0]      rd_data;
    logic [qphs_pkg::ADDR_W-1:0]       mem_addr;
    logic                              mem_we;
    logic [qphs_pkg::ENTRY_W-1:0]      mem_wdata;

    logic [qphs_pkg::SIZE_W-1:0]       size_eff;
    logic [qphs_pkg::SIZE_W-1:0]       rem_shift;
    logic [qphs_pkg::SIZE_W-1:0]       rem_next;
    logic [qphs_pkg::SIZE_W:0]         off_sum;
    logic [qphs_pkg::SIZE_W-1:0]       off_next;
    logic [qphs_pkg::SIZE_W:0]         pos_sum;
    logic [qphs_pkg::SIZE_W-1:0]       pos_next;
    logic                              entry_hit;
    logic                              entry_free;
    logic                              out_free;
    logic                              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == qphs_pkg::REG_TABLE_SIZE);
    assign prdata    = (paddr == qphs_pkg::REG_TABLE_SIZE)
                     ? {{(32-qphs_pkg::SIZE_W){1'b0}}, size_cfg_reg} : 32'd0;

    always_comb
    begin
        size_eff = size_cfg_reg;
        if (size_cfg_reg < qphs_pkg::SIZE_MIN)
        begin
            size_eff = qphs_pkg::SIZE_MIN;
        end
        else if (size_cfg_reg > qphs_pkg::SIZE_MAX)
        begin
            size_eff = qphs_pkg::SIZE_MAX;
        end
    end

    always_comb
    begin
        rem_shift = {rem_reg[qphs_pkg::SIZE_W-2:0], key_reg[bit_reg]};
        rem_next  = (rem_shift >= size_reg) ? rem_shift - size_reg : rem_shift;
        off_sum   = {1'b0, off_reg} + (qphs_pkg::SIZE_W+1)'(2);
        off_next  = (off_sum >= {1'b0, size_reg})
                  ? qphs_pkg::SIZE_W'(off_sum - {1'b0, size_reg})
                  : off_sum[qphs_pkg::SIZE_W-1:0];
        pos_sum   = {1'b0, pos_reg} + {1'b0, off_reg};
        pos_next  = (pos_sum >= {1'b0, size_reg})
                  ? qphs_pkg::SIZE_W'(pos_sum - {1'b0, size_reg})
                  : pos_sum[qphs_pkg::SIZE_W-1:0];
    end

    assign entry_hit  = rd_data[qphs_pkg::KEY_W] && (rd_data[qphs_pkg::KEY_W-1:0] == key_reg);
    assign entry_free = !rd_data[qphs_pkg::KEY_W];
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qphs_pkg::S_CLEAR:
            begin
                if (clr_reg == (qphs_pkg::ADDR_W+1)'(qphs_pkg::DEPTH - 1))
                begin
                    state_next = qphs_pkg::S_IDLE;
                end
            end
            qphs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = qphs_pkg::S_MOD;
                end
            end
            qphs_pkg::S_MOD:
            begin
                if (bit_reg == '0)
                begin
                    state_next = qphs_pkg::S_READ;
                end
            end
            qphs_pkg::S_READ:
            begin
                state_next = qphs_pkg::S_CHECK;
            end
            qphs_pkg::S_CHECK:
            begin
                if (probe_reg == qphs_pkg::PROBE_W'(qphs_pkg::PROBE_LIMIT - 1))
                begin
                    state_next = qphs_pkg::S_UPDATE;
                end
                else
                begin
                    state_next = qphs_pkg::S_READ;
                end
            end
            qphs_pkg::S_UPDATE:
            begin
                state_next = qphs_pkg::S_OUT;
            end
            qphs_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    state_next = qphs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = qphs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = pos_reg[qphs_pkg::ADDR_W-1:0];
        mem_wdata = '0;
        unique case (state_reg)
            qphs_pkg::S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg[qphs_pkg::ADDR_W-1:0];
            end
            qphs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
            end
            qphs_pkg::S_UPDATE:
            begin
                if (mode_reg == qphs_pkg::MODE_INSERT && !hit_reg && empty_reg)
                begin
                    mem_we    = 1'b1;
                    mem_addr  = empty_slot_reg;
                    mem_wdata = {1'b1, key_reg};
                end
                else if (mode_reg == qphs_pkg::MODE_DELETE && hit_reg)
                begin
                    mem_we   = 1'b1;
                    mem_addr = hit_slot_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qphs_pkg::S_CLEAR;
            size_cfg_reg  <= qphs_pkg::SIZE_RESET;
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                size_cfg_reg <= pwdata[qphs_pkg::SIZE_W-1:0];
            end
            if (state_reg == qphs_pkg::S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == qphs_pkg::S_UPDATE)
            begin
                if (mode_reg == qphs_pkg::MODE_INSERT && !hit_reg && empty_reg)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else if (mode_reg == qphs_pkg::MODE_DELETE && hit_reg && count_reg != '0)
                begin
                    count_reg <= count_reg - 1'b1;
                end
            end
            if (state_reg == qphs_pkg::S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            qphs_pkg::S_IDLE:
            begin
                mode_reg  <= qphs_pkg::mode_t'(mode);
                key_reg   <= key;
                size_reg  <= size_eff;
                bit_reg   <= qphs_pkg::BIT_W'(qphs_pkg::KEY_W - 1);
                rem_reg   <= '0;
                hit_reg   <= 1'b0;
                empty_reg <= 1'b0;
            end
            qphs_pkg::S_MOD:
            begin
                rem_reg <= rem_next;
                bit_reg <= bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    pos_reg   <= rem_next;
                    off_reg   <= qphs_pkg::SIZE_W'(1);
                    probe_reg <= '0;
                end
            end
            qphs_pkg::S_CHECK:
            begin
                if (!hit_reg && entry_hit)
                begin
                    hit_reg      <= 1'b1;
                    hit_slot_reg <= pos_reg[qphs_pkg::ADDR_W-1:0];
                end
                if (!empty_reg && entry_free)
                begin
                    empty_reg      <= 1'b1;
                    empty_slot_reg <= pos_reg[qphs_pkg::ADDR_W-1:0];
                end
                pos_reg   <= pos_next;
                off_reg   <= off_next;
                probe_reg <= probe_reg + 1'b1;
            end
            qphs_pkg::S_UPDATE:
            begin
                res_found_reg <= hit_reg;
                res_slot_reg  <= hit_reg ? hit_slot_reg : '0;
                unique case (mode_reg)
                    qphs_pkg::MODE_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            res_status_reg <= qphs_pkg::ST_PRESENT;
                        end
                        else if (empty_reg)
                        begin
                            res_status_reg <= qphs_pkg::ST_DONE;
                            res_slot_reg   <= empty_slot_reg;
                        end
                        else
                        begin
                            res_status_reg <= qphs_pkg::ST_FULL;
                        end
                    end
                    default:
                    begin
                        res_status_reg <= hit_reg ? qphs_pkg::ST_DONE : qphs_pkg::ST_ABSENT;
                    end
                endcase
            end
            qphs_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    out_status_reg <= res_status_reg;
                    out_found_reg  <= res_found_reg;
                    out_slot_reg   <= res_slot_reg;
                    out_count_reg  <= count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign found     = out_found_reg;
    assign slot      = out_slot_reg;
    assign count     = out_count_reg;

endmodule
